// ===== rtl/core/pfv_pkg.sv =====
// Package for pixel_fade_vignette: widths, register indexes, shared types.
// No dependencies.
`default_nettype none
package pfv_pkg;
  localparam int MaxDim    = 4096;
  localparam int DimW      = 13;            // register width
  localparam int PosW      = 12;            // coordinate width
  localparam int QW        = 11;            // q in 0..1999
  localparam int TW        = 20;            // t in 0..1000000
  localparam int ProdW     = 40;            // t_row * t_col
  localparam int ChW       = 8;
  localparam int DivW      = 48;            // prod * channel
  localparam logic [DivW-1:0] Scale = 48'd1000000000000;
  localparam int CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  typedef logic [31:0] pixel_t;
  typedef struct packed {
    pixel_t     word;
    logic       eof;
  } result_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pfv_stream_if.sv =====
// Valid/ready stream interfaces: one carries pixels in, one carries results out.
// No dependencies.
`default_nettype none
interface pfv_pixel_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [31:0] pixel_word;
  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

interface pfv_result_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [31:0] faded_word;
  logic end_of_frame;
  modport source (output valid, output faded_word, output end_of_frame, input ready);
  modport sink (input valid, input faded_word, input end_of_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pfv_serdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pfv_pkg.
`default_nettype none
module pfv_serdiv (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [pfv_pkg::DivW-1:0] dividend,
  input  wire logic [pfv_pkg::DivW-1:0] divisor,
  output logic                          done,
  output logic [pfv_pkg::DivW-1:0]      quotient
);
  import pfv_pkg::*;
  localparam int CntW = $clog2(DivW + 1);
  logic [DivW-1:0] rem, quo, dsr;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   trial;
  logic [DivW-1:0] shifted;

  assign shifted  = {rem[DivW-2:0], quo[DivW-1]};
  assign trial    = {rem, quo[DivW-1]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == CntW'(1));
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      quo  <= dividend;
      dsr  <= divisor;
      cnt  <= CntW'(DivW);
    end else if (busy) begin
      if (!trial[DivW]) begin
        rem <= trial[DivW-1:0];
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DivW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pixel_fade_vignette.sv =====
// Top level of pixel_fade_vignette: sequencer around one shared serial divider.
// Depends on pfv_pkg, pfv_stream_if, pfv_serdiv.
//
// Use: RGBA pixels arrive in raster order on the pixel_in channel
// (valid/ready, request accepted when both high). Each produces one result
// on result_out: red, green and blue faded by a weight that falls to black
// at the top row and left column, alpha untouched, end_of_frame on the last
// pixel of the frame.
// Sequence: one item at a time through a 48-bit bit-serial divider, used
// five times (q for row, q for column, then red, green, blue scaled by
// 10^12); the t product is formed between the q passes and the channel
// passes. The divider's loop yields one quotient bit per cycle.
// Flow: one pixel at a time; the next request can be taken the cycle
// after the previous result is taken.
// Stall: the result holds in the output register until taken; no new
// request is taken meanwhile.
// Reset: frame 640 x 480, positions zero. Any register write to a valid
// index also restarts the frame at row 0, column 0.
`default_nettype none
module pixel_fade_vignette (
  input  wire logic              clk,
  input  wire logic              rst,
  pfv_pixel_if.sink              pixel_in,
  pfv_result_if.source           result_out,
  input  wire logic              cfg_we,
  input  wire logic [pfv_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [pfv_pkg::DimW-1:0]    cfg_data
);
  import pfv_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_QR = 4'd1, S_QC = 4'd2, S_TMUL = 4'd3,
                         S_PMUL = 4'd4, S_CH = 4'd5, S_WAIT = 4'd6, S_OUT = 4'd7;

  logic [DimW-1:0] frame_width, frame_height, w, h;
  logic [PosW-1:0] row_position, column_position, row, col;
  logic [3:0]      state;
  logic [1:0]      ch_idx;
  pixel_t          px;
  logic [PosW-1:0] col_hold;
  logic [TW-1:0]   t_row, t_col;
  logic [ProdW-1:0] prod;
  logic [ChW-1:0]  rgb [3];
  logic            eof, last_col, last_row;
  logic            take;

  logic            div_start, div_done;
  logic [DivW-1:0] div_a, div_b, div_q;
  logic [QW-1:0]   qsat;
  logic signed [QW:0] dq;
  logic signed [2*QW+1:0] dsq;
  logic [TW-1:0]   tval;
  logic [ChW-1:0]  chan;

  assign w = eff_dim(frame_width);
  assign h = eff_dim(frame_height);
  // positions past a shrunk frame clamp to its last row or column
  assign col = ({1'b0, column_position} >= w) ? PosW'(w - 1'b1) : column_position;
  assign row = ({1'b0, row_position} >= h) ? PosW'(h - 1'b1) : row_position;
  assign last_col = ({1'b0, col} == w - 1'b1);
  assign last_row = ({1'b0, row} == h - 1'b1);
  assign take = pixel_in.valid && (state == S_IDLE);
  // q clamps to 1999; t = 10^6 - (q-1000)^2
  assign qsat = (div_q > DivW'(1999)) ? QW'(1999) : div_q[QW-1:0];
  assign dq   = $signed({1'b0, qsat}) - $signed((QW+1)'(1000));
  assign dsq  = dq * dq;
  assign tval = TW'(1000000) - dsq[TW-1:0];
  assign chan = px[31 - 8*ch_idx -: 8];

  pfv_serdiv u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  assign pixel_in.ready        = (state == S_IDLE);
  assign result_out.valid      = (state == S_OUT);
  assign result_out.faded_word = {rgb[0], rgb[1], rgb[2], px[7:0]};
  assign result_out.end_of_frame = eof;

  always_ff @(posedge clk) begin
    div_start <= !rst && (take || ((state == S_QR) && div_done) || (state == S_PMUL));
    if (rst) begin
      frame_width     <= DimW'(640);
      frame_height    <= DimW'(480);
      row_position    <= '0;
      column_position <= '0;
      state           <= S_IDLE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegWidth:  frame_width  <= cfg_data;
          RegHeight: frame_height <= cfg_data;
          default: ;
        endcase
        row_position    <= '0;
        column_position <= '0;
      end else if (take) begin
        if (last_col) begin
          column_position <= '0;
          row_position    <= last_row ? '0 : row + 1'b1;
        end else begin
          column_position <= col + 1'b1;
        end
      end
      unique case (state)
        S_IDLE: if (pixel_in.valid) begin
          px  <= pixel_in.pixel_word;
          eof <= last_col && last_row;
          div_a <= DivW'(2000) * DivW'(row);
          div_b <= DivW'(h);
          col_hold <= col;  // column parked until row quotient returns
          state <= S_QR;
        end
        S_QR: if (div_done) begin
          t_row <= tval;
          div_a <= DivW'(2000) * DivW'(col_hold);
          div_b <= DivW'(w);
          state <= S_QC;
        end
        S_QC: if (div_done) begin
          t_col <= tval;
          state <= S_TMUL;
        end
        S_TMUL: begin
          prod   <= t_row * t_col;
          ch_idx <= 2'd0;
          state  <= S_PMUL;
        end
        S_PMUL: begin
          div_a <= prod * DivW'(chan);
          div_b <= Scale;
          state <= S_CH;
        end
        S_CH: if (div_done) begin
          rgb[ch_idx] <= (div_q > DivW'(255)) ? 8'hFF : div_q[ChW-1:0];
          if (ch_idx == 2'd2) state <= S_OUT;
          else begin
            ch_idx <= ch_idx + 1'b1;
            state  <= S_PMUL;
          end
        end
        S_OUT: if (result_out.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_pixel_fade_vignette.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pixel_fade_vignette: a stimulus table, then random frames.
// Depends on pfv_pkg, pfv_stream_if and the pixel_fade_vignette RTL.
module tb_pixel_fade_vignette;
  import pfv_pkg::*;

  localparam int RandomPixels = 1500;
  localparam int CycleLimit   = 2500000;  // room for every pixel's divider passes plus stalls, several times over

  // One row of the stimulus table: a register write or a pixel request
  typedef struct {
    bit                 wr;
    logic [CfgIdxW-1:0] idx;
    logic [DimW-1:0]    data;
    pixel_t             px;
    bit                 typed;   // expected result given by hand
    result_t            want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegWidth;
  logic [DimW-1:0]    cfg_data  = '0;

  pfv_pixel_if  pin  (clk);
  pfv_result_if rout (clk);

  pixel_fade_vignette u_dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pin),
    .result_out (rout),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: mirrors of the two registers and the raster position
  logic [DimW-1:0] frame_w = DimW'(640);
  logic [DimW-1:0] frame_h = DimW'(480);
  int unsigned     row_at  = 0;
  int unsigned     col_at  = 0;

  result_t faded_q[$];      // expected results, oldest first
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  bit      quiet          = 1'b0;  // no idling on either side while set
  bit      typed_now      = 1'b0;  // current request carries a hand-typed result
  result_t typed_want;

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  // weight in 0..10^6, zero at coordinate 0, peak at mid-frame
  function automatic longint unsigned vignette_weight(int unsigned x, int unsigned n);
    longint unsigned q;
    longint          d;
    q = (64'd2000 * x) / n;
    if (q > 1999) q = 1999;
    d = longint'(q) - 1000;
    return 64'd1000000 - longint'(d * d);
  endfunction

  function automatic logic [7:0] fade_channel(longint unsigned prod, logic [7:0] ch);
    longint unsigned v;
    v = (prod * ch) / 64'd1000000000000;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Works out the result for one pixel and advances the raster position
  function automatic result_t fade_pixel(pixel_t px);
    int unsigned     w, h, c, r;
    longint unsigned prod;
    result_t         res;
    w = clamp_dim(frame_w);
    h = clamp_dim(frame_h);
    c = (col_at >= w) ? w - 1 : col_at;
    r = (row_at >= h) ? h - 1 : row_at;
    prod = vignette_weight(r, h) * vignette_weight(c, w);
    res.word = {fade_channel(prod, px[31:24]), fade_channel(prod, px[23:16]),
                fade_channel(prod, px[15:8]), px[7:0]};
    res.eof  = (c == w - 1) && (r == h - 1);
    if (c == w - 1) begin
      col_at = 0;
      row_at = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
    return res;
  endfunction

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < 9);
  endfunction

  // Sampling at the rising edge: register writes, accepted requests, results
  always @(posedge clk) begin
    result_t got, want, pred;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("pixel_fade_vignette: mismatch");
      $finish;
    end
    if (!rst && cfg_we) begin
      if (cfg_index == RegWidth) frame_w = cfg_data;
      else frame_h = cfg_data;
      row_at = 0;
      col_at = 0;
    end
    if (!rst && pin.valid && pin.ready) begin
      pred = fade_pixel(pin.pixel_word);
      faded_q.push_back(typed_now ? typed_want : pred);
    end
    if (!rst && rout.valid && rout.ready) begin
      got.word = rout.faded_word;
      got.eof  = rout.end_of_frame;
      if (faded_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h eof %b", got.word, got.eof);
      end else begin
        want = faded_q.pop_front();
        if (got.word !== want.word || got.eof !== want.eof) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result: expected %h eof %b, got %h eof %b",
                     want.word, want.eof, got.word, got.eof);
        end
      end
    end
  end

  // Receiver stalls at random
  always @(negedge clk) rout.ready <= !idle_roll();

  task automatic send_pixel(pixel_t px, bit typed, result_t want);
    @(negedge clk);
    while (idle_roll()) begin
      pin.valid <= 1'b0;
      @(negedge clk);
    end
    typed_now  = typed;
    typed_want = want;
    pin.valid      <= 1'b1;
    pin.pixel_word <= px;
    do @(posedge clk); while (!pin.ready);
  endtask

  // Holds off the sender until every expected result is back
  task automatic drain();
    @(negedge clk);
    pin.valid <= 1'b0;
    while (faded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic step_t px_row(pixel_t px, bit typed, pixel_t w, bit eof);
    step_t s;
    s = '{wr: 1'b0, idx: RegWidth, data: '0, px: px, typed: typed, want: '{w, eof}};
    return s;
  endfunction

  function automatic step_t wr_row(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
    step_t s;
    s = '{wr: 1'b1, idx: idx, data: data, px: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  initial begin
    step_t       table_q[$];
    int unsigned sent, n, w, h, area;
    pixel_t      px;
    pin.valid      = 1'b0;
    pin.pixel_word = '0;
    rout.ready     = 1'b0;

    // after reset: top-left corner is black, alpha kept
    table_q.push_back(px_row(32'hFFFF_FFFF, 1, 32'h0000_00FF, 0));
    table_q.push_back(px_row(32'h1234_5678, 0, '0, 0));
    // 1 x 1 frame: every pixel is the corner and the last of its frame
    table_q.push_back(wr_row(RegWidth, 13'd1));
    table_q.push_back(wr_row(RegHeight, 13'd1));
    table_q.push_back(px_row(32'hFFFF_FFFF, 1, 32'h0000_00FF, 1));
    table_q.push_back(px_row(32'h0000_0000, 1, 32'h0000_0000, 1));
    // zero sizes are taken as one
    table_q.push_back(wr_row(RegWidth, 13'd0));
    table_q.push_back(wr_row(RegHeight, 13'd0));
    table_q.push_back(px_row(32'hAAAA_AAAA, 1, 32'h0000_00AA, 1));
    // 2 x 2: only the centre pixel at (1,1) keeps full weight
    table_q.push_back(wr_row(RegWidth, 13'd2));
    table_q.push_back(wr_row(RegHeight, 13'd2));
    table_q.push_back(px_row(32'hFFFF_FFFF, 1, 32'h0000_00FF, 0));
    table_q.push_back(px_row(32'hFFFF_FF00, 1, 32'h0000_0000, 0));
    table_q.push_back(px_row(32'h5555_5555, 1, 32'h0000_0055, 0));
    table_q.push_back(px_row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1));
    // oversize registers clamp to the largest frame
    table_q.push_back(wr_row(RegWidth, 13'h1FFF));
    table_q.push_back(wr_row(RegHeight, 13'd4096));
    table_q.push_back(px_row(32'h8040_2010, 0, '0, 0));
    table_q.push_back(px_row(32'hFFFF_FFFF, 0, '0, 0));
    table_q.push_back(wr_row(RegHeight, 13'h1FFF));
    table_q.push_back(px_row(32'h7F7F_7F7F, 0, '0, 0));
    // odd sizes, predictor checked
    table_q.push_back(wr_row(RegWidth, 13'd3));
    table_q.push_back(wr_row(RegHeight, 13'd5));
    for (int i = 0; i < 16; i++) table_q.push_back(px_row($urandom, 0, '0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_q[i]) begin
      if (table_q[i].wr) begin
        drain();
        write_reg(table_q[i].idx, table_q[i].data);
      end else begin
        send_pixel(table_q[i].px, table_q[i].typed, table_q[i].want);
      end
    end

    // Random frames: mostly small sizes so frames complete often
    sent = 0;
    while (sent < RandomPixels) begin
      drain();
      case ($urandom_range(11))
        0:       w = 0;
        1:       w = 13'h1FFF;
        2:       w = 4096;
        3:       w = $urandom_range(4097, 8191);
        default: w = $urandom_range(1, 12);
      endcase
      h = ($urandom_range(7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
      case ($urandom_range(2))
        0:       write_reg(RegWidth, w[DimW-1:0]);
        1:       write_reg(RegHeight, h[DimW-1:0]);
        default: begin
          write_reg(RegWidth, w[DimW-1:0]);
          write_reg(RegHeight, h[DimW-1:0]);
        end
      endcase
      area = clamp_dim(frame_w) * clamp_dim(frame_h);
      n = (area <= 150) ? area * $urandom_range(1, 3) + $urandom_range(0, 4)
                        : $urandom_range(10, 60);
      quiet = ($urandom_range(7) == 0);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(15))
          0:       px = 32'hFFFF_FFFF;
          1:       px = 32'h0000_0000;
          default: px = $urandom;
        endcase
        send_pixel(px, 0, '0);
      end
      quiet = 1'b0;
      sent += n;
    end

    drain();
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && faded_q.size() == 0)
      $display("pixel_fade_vignette: match");
    else
      $display("pixel_fade_vignette: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/pfv_pkg.sv
rtl/core/pfv_stream_if.sv
rtl/core/pfv_serdiv.sv
rtl/core/pixel_fade_vignette.sv
tb/tb_pixel_fade_vignette.sv
